### src/sss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg
// shared constants, exp table and fixed-point helpers of the scan unit
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned SumW    = 40;
  localparam int unsigned ProdW   = 66;
  localparam int unsigned InDataW = 200;

  localparam logic [32:0] Log2eQ30 = 33'd1549082005;
  localparam logic [32:0] Ln2Q24   = 33'd11629080;
  // floor(v/6) as (v*Recip6) >> 16 for v below 2^12
  localparam logic [32:0] Recip6   = 33'd10923;

  typedef logic signed [ProdW-1:0] prod_t;

  // q2.24 values of 2^(i/16)
  function automatic logic [25:0] pow2_frac(input logic [3:0] i);
    logic [25:0] r;
    case (i)
      4'd0:  r = 26'd16777216;
      4'd1:  r = 26'd17520007;
      4'd2:  r = 26'd18295684;
      4'd3:  r = 26'd19105703;
      4'd4:  r = 26'd19951585;
      4'd5:  r = 26'd20834917;
      4'd6:  r = 26'd21757357;
      4'd7:  r = 26'd22720638;
      4'd8:  r = 26'd23726566;
      4'd9:  r = 26'd24777031;
      4'd10: r = 26'd25874004;
      4'd11: r = 26'd27019544;
      4'd12: r = 26'd28215802;
      4'd13: r = 26'd29465022;
      4'd14: r = 26'd30769550;
      default: r = 26'd32131834;
    endcase
    return r;
  endfunction

  function automatic prod_t sx32(input logic [31:0] v);
    return {{(ProdW-32){v[31]}}, v};
  endfunction

  // round half up from q32 products back to q16
  function automatic prod_t qround(input prod_t v);
    return (v + 66'sd32768) >>> 16;
  endfunction

  function automatic logic [31:0] sat32(input prod_t v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [SumW-1:0] sat40(input prod_t v);
    logic [SumW-1:0] r;
    if (v > 66'sd549755813887) r = 40'h7F_FFFF_FFFF;
    else if (v < -66'sd549755813888) r = 40'h80_0000_0000;
    else r = v[SumW-1:0];
    return r;
  endfunction

endpackage

### src/selective_state_space_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_state_space_scan_unit
// s6 selective scan: per (time step, state element) beat updates one hidden
// state h = exp(step*a)*h + step*b*u, accumulates c*h, emits sum + d*u
// ----------------------------------------------------------------------------
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: step,u,a,b,c,d,index
//                                             tuser: seq_start
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: y_value
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i: state_count
//
// an in-range beat steps through one shared 33x33 multiplier (one product
// per cycle) with a final step on the last element; out-of-range beats are
// dropped on accept. hidden state lives in a ram read at accept and
// written back once; per-entry valid bits give the zero reset at once.
// a finished result waits in the output register, the next beat is taken
// meanwhile; only a second result stalls in its final step until taken.
// ----------------------------------------------------------------------------
module selective_state_space_scan_unit #(
  parameter int unsigned MAX_STATES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // step[31:0] u[63:32] a[95:64] b[127:96] c[159:128] d[191:160] index[195:192]
  input  logic [sss_pkg::InDataW-1:0] s_axis_tdata,
  // seq_start[0]
  input  logic                        s_axis_tuser,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // y_value[31:0]
  output logic [sss_pkg::DataW-1:0]   m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sss_pkg::CountW-1:0]  cfg_data_i
);
  import sss_pkg::*;

  localparam int unsigned AW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam logic [6:0]  MaxCnt = 7'(MAX_STATES);

  typedef enum logic [3:0] {
    S_IDLE, S_SA, S_X, S_P, S_Z, S_Z2, S_Z3, S_Q, S_M, S_SB, S_BU, S_H, S_C, S_D
  } state_e;

  state_e state_q;
  logic [CountW-1:0] count_q;
  logic [DataW-1:0]  step_q, u_q, a_q, b_q, c_q, d_q;
  logic [IdxW-1:0]   idx_q;
  logic              start_q, hval_q, last_q;
  logic [AW-1:0]     addr_q;
  logic [MAX_STATES-1:0] valid_q;
  prod_t             prod_q;
  logic signed [19:0] n_q;
  logic [15:0]       f16_q;
  logic [19:0]       z_q;
  logic [39:0]       z2_q;
  logic [DataW-1:0]  da_q, dbu_q;
  logic [SumW-1:0]   sum_q, sum_tmp_q;
  logic              out_valid_q;
  logic [DataW-1:0]  out_data_q;
  logic              emit;

  // input decode
  logic [IdxW-1:0]    in_idx;
  logic [AW+IdxW-1:0] idx_ext;
  logic [AW-1:0]      in_addr;
  logic [6:0]         cnt_eff;
  logic               in_acc, in_range, in_last;

  assign in_idx  = s_axis_tdata[195:192];
  assign idx_ext = {{AW{1'b0}}, in_idx};
  assign in_addr = idx_ext[AW-1:0];

  // state_count clamped to 1..MAX_STATES
  always_comb begin
    cnt_eff = {2'b00, count_q};
    if (cnt_eff == 7'd0) cnt_eff = 7'd1;
    if (cnt_eff > MaxCnt) cnt_eff = MaxCnt;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_range = ({3'b000, in_idx} < cnt_eff);
  assign in_last  = ({3'b000, in_idx} == (cnt_eff - 7'd1));

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // final step may hand its result over when the output register frees up
  assign emit = (state_q == S_D) && (!out_valid_q || m_axis_tready);

  // hidden state ram
  logic [DataW-1:0] ram_rdata;
  logic             ram_we;
  logic [DataW-1:0] h_new;

  sss_ram #(.WIDTH(DataW), .DEPTH(MAX_STATES)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (h_new),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  assign ram_we = (state_q == S_H);

  // datapath helpers
  prod_t       rnd;
  logic [31:0] rnd_sat;
  logic [25:0] q_poly;
  logic [26:0] mant;
  logic [31:0] da_val;
  logic [31:0] h_old;
  prod_t       sum_new, y_full;
  logic signed [20:0] sh_r;
  logic [63:0] shv;
  logic signed [32:0] mul_a, mul_b;

  assign rnd     = qround(prod_q);
  assign rnd_sat = sat32(rnd);
  assign h_new   = sat32(rnd + sx32(dbu_q));
  assign h_old   = (start_q || !hval_q) ? '0 : ram_rdata;
  assign mant    = prod_q[50:24];
  // 2^24 + z + z^2/2 + z^3/6 in q2.24
  assign q_poly  = 26'd16777216 + {6'd0, z_q} + {11'd0, z2_q[39:25]}
                 + {16'd0, prod_q[25:16]};
  assign sh_r    = 21'sd8 - {n_q[19], n_q};

  // exp scaling of the mantissa by 2^(n-8)
  always_comb begin
    shv = '0;
    if (n_q >= 20'sd15) begin
      da_val = 32'h7FFF_FFFF;
    end else if (n_q >= 20'sd8) begin
      shv    = {37'd0, mant} << (6'(n_q - 20'sd8));
      da_val = sat32({2'b00, shv});
    end else if (sh_r > 21'sd40) begin
      da_val = '0;
    end else begin
      shv    = ({37'd0, mant} + (64'd1 << (sh_r[5:0] - 6'd1))) >> sh_r[5:0];
      da_val = sat32({2'b00, shv});
    end
  end

  always_comb begin
    sum_new = ((idx_q == '0) ? '0 : {{(ProdW-SumW){sum_q[SumW-1]}}, sum_q}) + rnd;
    y_full  = {{(ProdW-SumW){sum_tmp_q[SumW-1]}}, sum_tmp_q} + rnd;
  end

  // operand select of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SA: begin mul_a = {step_q[31], step_q}; mul_b = {a_q[31], a_q}; end
      S_X:  begin mul_a = {rnd_sat[31], rnd_sat}; mul_b = Log2eQ30; end
      S_P:  begin mul_a = {21'd0, prod_q[41:30]}; mul_b = Ln2Q24; end
      S_Z:  begin mul_a = {13'd0, prod_q[35:16]}; mul_b = {13'd0, prod_q[35:16]}; end
      S_Z2: begin mul_a = {17'd0, prod_q[39:24]}; mul_b = {13'd0, z_q}; end
      S_Z3: begin mul_a = {21'd0, prod_q[35:24]}; mul_b = Recip6; end
      S_Q:  begin mul_a = {7'd0, pow2_frac(f16_q[15:12])}; mul_b = {7'd0, q_poly}; end
      S_M:  begin mul_a = {step_q[31], step_q}; mul_b = {b_q[31], b_q}; end
      S_SB: begin mul_a = {rnd_sat[31], rnd_sat}; mul_b = {u_q[31], u_q}; end
      S_BU: begin mul_a = {da_q[31], da_q}; mul_b = {h_old[31], h_old}; end
      S_H:  begin mul_a = {c_q[31], c_q}; mul_b = {h_new[31], h_new}; end
      // d*u is held while the final step waits on the output
      S_C, S_D: begin mul_a = {d_q[31], d_q}; mul_b = {u_q[31], u_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= 5'd16;
      valid_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prod_q <= mul_a * mul_b;
      if (cfg_valid_i) count_q <= cfg_data_i;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_range) begin
            step_q  <= s_axis_tdata[31:0];
            u_q     <= s_axis_tdata[63:32];
            a_q     <= s_axis_tdata[95:64];
            b_q     <= s_axis_tdata[127:96];
            c_q     <= s_axis_tdata[159:128];
            d_q     <= s_axis_tdata[191:160];
            idx_q   <= in_idx;
            start_q <= s_axis_tuser;
            addr_q  <= in_addr;
            hval_q  <= valid_q[in_addr];
            last_q  <= in_last;
            state_q <= S_SA;
          end
        end
        S_SA: state_q <= S_X;
        S_X:  state_q <= S_P;
        S_P: begin
          n_q     <= prod_q[65:46];
          f16_q   <= prod_q[45:30];
          state_q <= S_Z;
        end
        S_Z: begin
          z_q     <= prod_q[35:16];
          state_q <= S_Z2;
        end
        S_Z2: begin
          z2_q    <= prod_q[39:0];
          state_q <= S_Z3;
        end
        S_Z3: state_q <= S_Q;
        S_Q:  state_q <= S_M;
        S_M: begin
          da_q    <= da_val;
          state_q <= S_SB;
        end
        S_SB: state_q <= S_BU;
        S_BU: begin
          dbu_q   <= rnd_sat;
          state_q <= S_H;
        end
        S_H: begin
          valid_q[addr_q] <= 1'b1;
          state_q <= S_C;
        end
        S_C: begin
          if (last_q) begin
            sum_tmp_q <= sat40(sum_new);
            state_q   <= S_D;
          end else begin
            sum_q   <= sat40(sum_new);
            state_q <= S_IDLE;
          end
        end
        S_D: begin
          if (emit) begin
            out_data_q  <= sat32(y_full);
            sum_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // an in-range beat always starts the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_range) |=> (state_q == S_SA))
    else $error("in-range beat did not start the sequence");

  // dropped beats leave the unit idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_range) |=> (state_q == S_IDLE))
    else $error("out-of-range beat was processed");

  // write-back marks its entry valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(addr_q)])
    else $error("written entry not marked valid");

  // emission clears the running sum and raises the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D && (!out_valid_q || m_axis_tready)) |=> (sum_q == '0 && out_valid_q))
    else $error("emission did not clear sum");

endmodule

### src/sss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### dv/selective_state_space_scan_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_state_space_scan_unit_tb
// self-checking bench for the s6 scan unit: a directed table, then random
// channel sequences over several state counts; every output beat is checked
// against a bit-exact fixed-point model of the recurrence kept in the bench,
// or against the y value typed into a directed table entry that carries one
module selective_state_space_scan_unit_tb;
  import sss_pkg::*;

  localparam int unsigned NumStates = 16;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DrainWait = 40;
  localparam int unsigned HoldOff   = 300;
  localparam longint      Q16Max    = 64'sd2147483647;
  localparam longint      Q16Min    = -64'sd2147483648;
  localparam longint      AccMax    = 64'sd549755813887;
  localparam longint      AccMin    = -64'sd549755813888;
  localparam logic [31:0] One       = 32'h0001_0000;
  localparam logic [31:0] MaxV      = 32'h7FFF_FFFF;
  localparam logic [31:0] MinV      = 32'h8000_0000;

  typedef struct {
    logic [31:0] step;
    logic [31:0] u;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [3:0]  idx;
    logic        start;
    bit          has_y;
    logic [31:0] y;
  } scan_beat_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DataW-1:0]     m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CountW-1:0]    cfg_data_i;

  // bench copy of the block state
  longint      hidden_q16 [NumStates];
  longint      acc_sum;
  logic [4:0]  count_reg;
  logic [31:0] y_expected_q [$];

  scan_beat_t  cur_beat;
  int unsigned in_beats, out_beats, cfg_beats, results_seen, errors;
  int unsigned idle_cycles;
  bit          hold_req;
  bit          no_gaps;

  longint pow2_tab [16] = '{
    16777216, 17520007, 18295684, 19105703, 19951585, 20834917, 21757357, 22720638,
    23726566, 24777031, 25874004, 27019544, 28215802, 29465022, 30769550, 32131834
  };

  selective_state_space_scan_unit #(.MAX_STATES(NumStates)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model
  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > Q16Max) return Q16Max;
    if (v < Q16Min) return Q16Min;
    return v;
  endfunction

  function automatic longint clamp40(input longint v);
    if (v > AccMax) return AccMax;
    if (v < AccMin) return AccMin;
    return v;
  endfunction

  // q16 x q16 rounded half up back to q16
  function automatic longint fx_mul(input longint x, input longint y);
    return (x * y + 64'sd32768) >>> 16;
  endfunction

  // 2^(x*log2e): table on the top fraction bits, cubic on the rest
  function automatic longint fx_exp(input longint x);
    longint p, n, f16, r, z, z2, q, m, sh;
    p   = x * 64'sd1549082005;
    n   = p >>> 46;
    f16 = (p >>> 30) & 64'sd65535;
    r   = f16 & 64'sd4095;
    z   = (r * 64'sd11629080) >>> 16;
    z2  = z * z;
    q   = 64'sd16777216 + z + (z2 >>> 25) + ((((z2 >>> 24) * z) >>> 24) / 6);
    m   = (pow2_tab[f16 >>> 12] * q) >>> 24;
    if (n >= 15) return Q16Max;
    sh = n - 8;
    if (sh >= 0) return clamp32(m <<< sh);
    sh = -sh;
    if (sh > 40) return 0;
    return clamp32((m + (64'sd1 <<< (sh - 1))) >>> sh);
  endfunction

  // advance the recurrence by one beat; returns 1 when a y value comes out
  function automatic bit scan_update(input scan_beat_t bt, output logic [31:0] y);
    longint eff, decay, drive, h, sum;
    int     s;
    eff = (count_reg < 1) ? 1 : ((count_reg > NumStates) ? NumStates : count_reg);
    s   = bt.idx;
    y   = '0;
    if (s >= eff) return 0;
    decay = fx_exp(clamp32(fx_mul(sx(bt.step), sx(bt.a))));
    drive = clamp32(fx_mul(clamp32(fx_mul(sx(bt.step), sx(bt.b))), sx(bt.u)));
    h = bt.start ? 0 : hidden_q16[s];
    h = clamp32(fx_mul(decay, h) + drive);
    hidden_q16[s] = h;
    sum = (s == 0) ? 0 : acc_sum;
    sum = clamp40(sum + fx_mul(sx(bt.c), h));
    if (s == eff - 1) begin
      y = clamp32(sum + fx_mul(sx(bt.d), sx(bt.u)));
      acc_sum = 0;
      return 1;
    end
    acc_sum = sum;
    return 0;
  endfunction

  // ---------------------------------------------------------------- monitors
  always @(posedge clk_i) begin
    scan_beat_t  bt;
    logic [31:0] y;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      count_reg = cfg_data_i;
      cfg_beats++;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      // decode straight off the bus so the model sees what the block saw
      bt       = cur_beat;
      bt.step  = s_axis_tdata[31:0];
      bt.u     = s_axis_tdata[63:32];
      bt.a     = s_axis_tdata[95:64];
      bt.b     = s_axis_tdata[127:96];
      bt.c     = s_axis_tdata[159:128];
      bt.d     = s_axis_tdata[191:160];
      bt.idx   = s_axis_tdata[195:192];
      bt.start = s_axis_tuser;
      if (scan_update(bt, y)) begin
        // typed table entries override the model value
        y_expected_q.push_back(bt.has_y ? bt.y : y);
      end
      in_beats++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (y_expected_q.size() == 0) begin
        $display("%0t: unexpected y beat, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        y = y_expected_q.pop_front();
        if (m_axis_tdata !== y) begin
          $display("%0t: y_value mismatch, expected %h, actual %h", $time, y, m_axis_tdata);
          errors++;
        end
      end
      out_beats++;
      results_seen++;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout, %0d y values still pending", $time, y_expected_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    int unsigned stall, c0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (hold_req) begin
        // long hold-off so the unit backs up into its input
        stall    = HoldOff;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      c0 = out_beats;
      while (out_beats == c0) @(negedge clk_i);
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_beat(input scan_beat_t bt);
    int unsigned gap, c0;
    gap = no_gaps ? 0 : (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9));
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_beat      = bt;
    s_axis_tdata  = {4'b0, bt.idx, bt.d, bt.c, bt.b, bt.a, bt.u, bt.step};
    s_axis_tuser  = bt.start;
    s_axis_tvalid = 1'b1;
    c0 = in_beats;
    @(negedge clk_i);
    while (in_beats == c0) @(negedge clk_i);
  endtask

  // sender pause: lower valid, wait for every pending y, then let the pipe drain
  task automatic drain_outputs();
    s_axis_tvalid = 1'b0;
    while (y_expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [4:0] value);
    int unsigned c0;
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    c0 = cfg_beats;
    @(negedge clk_i);
    while (cfg_beats == c0) @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return MaxV;
          1: return MinV;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return $urandom;
      default: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
    endcase
  endfunction

  // channel-shaped traffic: full index sweeps with random content, some noise
  task automatic random_phase(input logic [4:0] count, input int unsigned n_items);
    int unsigned eff, sent;
    scan_beat_t  bt;
    logic        first;
    logic [31:0] d_gain;
    eff  = (count < 1) ? 1 : ((count > NumStates) ? NumStates : count);
    sent = 0;
    while (sent < n_items) begin
      first  = ($urandom_range(0, 7) == 0);
      d_gain = rand_q16();
      for (int s = 0; s < eff; s++) begin
        bt.step  = rand_q16();
        bt.u     = rand_q16();
        bt.a     = rand_q16();
        bt.b     = rand_q16();
        bt.c     = rand_q16();
        bt.d     = d_gain;
        bt.idx   = s[3:0];
        bt.start = first;
        bt.has_y = 1'b0;
        bt.y     = '0;
        if ($urandom_range(0, 11) == 0) begin
          // broken sequence: any index, any first-step flag
          bt.idx   = 4'($urandom_range(0, 15));
          bt.start = 1'($urandom_range(0, 1));
          bt.d     = $urandom;
        end
        send_beat(bt);
        if (bt.idx < eff) sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  scan_beat_t dir_tab [12];
  logic [4:0] phase_counts [10] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17,
                                    5'd5, 5'd16, 5'd3, 5'd8, 5'd2};

  initial begin
    // state count 2 for the table: index 1 closes each time step
    dir_tab = '{
      // first step, everything zero: h and sum stay zero
      '{'0,   '0,   '0,   '0,   '0,   '0,   4'd0,  1'b1, 1'b0, '0},
      // exp(0) * 0 + 0, so y is just d*u = 1.0
      '{'0,   One,  '0,   '0,   '0,   One,  4'd1,  1'b1, 1'b1, One},
      // index beyond the count is dropped
      '{One,  One,  One,  One,  One,  One,  4'd5,  1'b0, 1'b0, '0},
      '{MaxV, MaxV, MaxV, MaxV, MaxV, MaxV, 4'd0,  1'b0, 1'b0, '0},
      '{MaxV, MaxV, MaxV, MaxV, MaxV, MaxV, 4'd1,  1'b0, 1'b0, '0},
      '{MinV, MinV, MinV, MinV, MinV, MinV, 4'd0,  1'b0, 1'b0, '0},
      '{MinV, MinV, MinV, MinV, MinV, MinV, 4'd1,  1'b0, 1'b0, '0},
      // exp saturates high
      '{MaxV, One,  MaxV, '0,   One,  One,  4'd0,  1'b0, 1'b0, '0},
      // exp underflows to zero
      '{MaxV, One,  MinV, One,  One,  MinV, 4'd1,  1'b0, 1'b0, '0},
      '{One,  One,  -One, One,  One,  One,  4'd0,  1'b1, 1'b0, '0},
      '{One,  One,  -One, One,  One,  One,  4'd1,  1'b0, 1'b0, '0},
      '{One,  MinV, One,  One,  One,  One,  4'd15, 1'b1, 1'b0, '0}
    };
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    hold_req      = 1'b0;
    no_gaps       = 1'b0;
    count_reg     = 5'd16;
    acc_sum       = 0;
    for (int i = 0; i < NumStates; i++) hidden_q16[i] = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_count(5'd2);
    foreach (dir_tab[i]) send_beat(dir_tab[i]);
    drain_outputs();

    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      if (p == 6) begin
        // back-to-back offers against a stalled receiver
        hold_req = 1'b1;
        no_gaps  = 1'b1;
      end
      random_phase(phase_counts[p], 140);
      no_gaps = 1'b0;
      drain_outputs();
    end

    $display("covered %0d input beats, %0d y values, %0d count writes",
             in_beats, results_seen, cfg_beats);
    $display("state counts 0 to 31 incl. extremes, back-pressure hold-off and exp limits");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/sss_pkg.sv
src/sss_ram.sv
src/selective_state_space_scan_unit.sv
dv/selective_state_space_scan_unit_tb.sv
